@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an implication holds at every edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Assert that an implication holds in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mbmon_pkg.sv @@
// Package: types, constants and helpers of the motor poll monitor
package mbmon_pkg;

  localparam int unsigned MAX_SLAVES_DEF = 8;

  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_RX_BYTE  = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_OFF    = 2'd1;

  localparam logic CFG_MOTOR_COUNT = 1'b0;
  localparam logic CFG_MISS_LIMIT  = 1'b1;

  localparam logic [7:0]  FUNC_WRITE_REG = 8'h06;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic       link_enabled;
    logic [1:0] machine_mode;
    logic [3:0] tank_states;
    logic       power_on;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       pump_fail;
    logic [7:0] motor_onoff;
    logic       frame_accepted;
  } out_item_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;      // capture input item, apply immediate updates
    logic crc_step;  // fold one frame byte into the tx CRC
    logic emit_tx;   // load output with frame byte
    logic scan_step; // process one slave entry of the health scan
    logic emit_stat; // load output with status report
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic send_frame;
    logic do_scan;
    logic last_byte;
    logic last_scan;
  } sts_t;

  function automatic logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [1:0] pair(logic t);
    return t ? 2'b11 : 2'b00;
  endfunction

  function automatic logic [7:0] auto_map(logic [3:0] n, logic [3:0] t);
    logic [7:0] m;
    unique case (n)
      4'd1: m = {7'd0, |t};
      4'd2: m = {6'd0, t[2] | t[3], t[0] | t[1]};
      4'd3: m = {5'd0, t[2] | t[3], t[1], t[0]};
      4'd4: m = {4'd0, t};
      4'd5: m = {3'd0, t[3], t[2], t[1], pair(t[0])};
      4'd6: m = {2'd0, t[3], t[2], pair(t[1]), pair(t[0])};
      4'd7: m = {1'd0, t[3], pair(t[2]), pair(t[1]), pair(t[0])};
      4'd8: m = {pair(t[3]), pair(t[2]), pair(t[1]), pair(t[0])};
      default: m = 8'd0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/mbmon_ctrl.sv @@
// Controller: sequences frame bytes and the slave health scan
module mbmon_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_free,
  input  mbmon_pkg::sts_t    sts,
  output mbmon_pkg::cmd_t    cmd
);
  import mbmon_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_CRC  = 5'b00100,
    S_TX   = 5'b01000,
    S_SCAN = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts.send_frame) state_next = S_CRC;
        else if (sts.do_scan) state_next = S_SCAN;
        else state_next = S_IDLE;
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.last_byte) state_next = S_TX;
      end
      S_TX: begin
        if (out_free) begin
          cmd.emit_tx = 1'b1;
          if (sts.last_byte) state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.last_scan) begin
          if (out_free) begin
            cmd.emit_stat = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.scan_step = 1'b0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

@@ rtl/mbmon_dp.sv @@
// Datapath: slave table, receive buffer, frame builder and output register
module mbmon_dp #(
  parameter int unsigned MAX_SLAVES = mbmon_pkg::MAX_SLAVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mbmon_pkg::in_item_t   in_data,
  input  logic                  cfg_we,
  input  logic                  cfg_sel,
  input  logic [7:0]            cfg_data,
  input  mbmon_pkg::cmd_t       cmd,
  output mbmon_pkg::sts_t       sts,
  output logic                  out_free,
  input  logic                  out_stall,
  output logic                  out_valid,
  output mbmon_pkg::out_item_t  out_data
);
  import mbmon_pkg::*;

  localparam int IW = $clog2(MAX_SLAVES + 1);

  logic [3:0]  motor_count;
  logic [7:0]  miss_limit;
  logic [13:0] slave_status [MAX_SLAVES+1];
  logic [3:0]  poll_pointer, reply_pointer, rx_length;
  logic [15:0] rx_crc;
  logic [7:0]  rx_addr, rx_reg;
  logic [7:0]  onoff_map;
  in_item_t    item;
  logic [3:0]  n_act;
  logic [2:0]  bcnt;
  logic [15:0] tx_crc;
  logic [7:0]  frame_addr, frame_val;
  logic [IW-1:0] scan_idx;
  logic        fail, accepted;

  assign n_act = (motor_count > 4'(MAX_SLAVES)) ? 4'(MAX_SLAVES) : motor_count;
  assign out_free = !out_valid || !out_stall;

  assign sts.send_frame = (item.operation == OP_POLL) && (n_act != 4'd0) && item.link_enabled;
  assign sts.do_scan    = (item.operation == OP_COMPLETE);
  assign sts.last_byte  = (bcnt == 3'd7);
  assign sts.last_scan  = (scan_idx == IW'(MAX_SLAVES));

  // Select the frame byte at the byte counter
  logic [7:0] fbyte;
  always_comb begin
    unique case (bcnt)
      3'd0: fbyte = frame_addr;
      3'd1: fbyte = FUNC_WRITE_REG;
      3'd5: fbyte = frame_val;
      3'd6: fbyte = tx_crc[7:0];
      3'd7: fbyte = tx_crc[15:8];
      default: fbyte = 8'h00;
    endcase
  end

  // Pointer validity and poll map
  logic [3:0] ptr;
  logic [7:0] new_map;
  assign ptr = (poll_pointer >= 4'd1 && poll_pointer <= 4'(MAX_SLAVES)) ? poll_pointer : 4'd1;
  always_comb begin
    priority if (in_data.machine_mode == MODE_MANUAL) new_map = 8'hFF;
    else if (in_data.machine_mode == MODE_OFF) new_map = 8'h00;
    else new_map = auto_map(n_act, in_data.tank_states);
  end

  // Scan entry work
  logic [13:0] s_cur;
  logic        s_active;
  assign s_cur = slave_status[scan_idx];
  assign s_active = (4'(scan_idx) <= n_act) && item.power_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_count <= 4'd1;
      miss_limit <= 8'd3;
      poll_pointer <= 4'd1;
      reply_pointer <= 4'd1;
      rx_length <= 4'd0;
      rx_crc <= CRC_INIT;
      rx_addr <= 8'd0;
      rx_reg <= 8'd0;
      onoff_map <= 8'd0;
      out_valid <= 1'b0;
      for (int i = 0; i <= MAX_SLAVES; i++) slave_status[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == CFG_MOTOR_COUNT) motor_count <= cfg_data[3:0];
        else miss_limit <= cfg_data;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;

      // Take the item and apply its immediate updates
      if (cmd.load) begin
        item <= in_data;
        bcnt <= 3'd0;
        tx_crc <= CRC_INIT;
        scan_idx <= IW'(1);
        fail <= 1'b0;
        accepted <= 1'b0;
        unique case (in_data.operation)
          OP_RX_BYTE: begin
            rx_crc <= crc_add(rx_crc, in_data.rx_byte);
            if (rx_length == 4'd0) rx_addr <= in_data.rx_byte;
            if (rx_length == 4'd5) rx_reg <= in_data.rx_byte;
            if (rx_length != 4'd15) rx_length <= rx_length + 4'd1;
          end
          OP_POLL: begin
            onoff_map <= new_map;
            frame_addr <= {4'd0, ptr};
            frame_val <= {7'd0, new_map[3'(ptr - 4'd1)]};
            reply_pointer <= ptr;
            poll_pointer <= (n_act != 4'd0 && ptr < n_act) ? ptr + 4'd1 : 4'd1;
            if (n_act == 4'd0) begin
              for (int i = 1; i <= MAX_SLAVES; i++)
                slave_status[i] <= {slave_status[i][13:10], 10'd0};
            end else if (in_data.link_enabled) begin
              rx_length <= 4'd0;
              rx_crc <= CRC_INIT;
              rx_addr <= 8'd0;
              rx_reg <= 8'd0;
            end
          end
          OP_COMPLETE: begin
            if (!in_data.link_enabled) begin
              for (int i = 1; i <= MAX_SLAVES; i++)
                slave_status[i] <= {slave_status[i][13:10], 10'd0};
            end else if (rx_length == 4'd8 && rx_crc == 16'd0) begin
              accepted <= 1'b1;
              if (rx_addr <= 8'(MAX_SLAVES))
                slave_status[IW'(rx_addr)] <= {rx_reg[5:4], rx_reg[3:2], rx_reg[1], rx_reg[0],
                                                8'd0};
            end else if (reply_pointer <= 4'(MAX_SLAVES)) begin
              slave_status[IW'(reply_pointer)][7:0] <=
                (slave_status[IW'(reply_pointer)][7:0] < miss_limit) ?
                slave_status[IW'(reply_pointer)][7:0] + 8'd1 : miss_limit;
            end
          end
          default: ;
        endcase
      end

      // Fold frame bytes 0 to 5 into the CRC, skipping from byte 5 to byte 7, then one settle step wraps to 0
      if (cmd.crc_step) begin
        if (bcnt <= 3'd5) tx_crc <= crc_add(tx_crc, fbyte);
        bcnt <= (bcnt == 3'd5) ? 3'd7 : bcnt + 3'd1;
      end

      // Present one frame beat
      if (cmd.emit_tx) begin
        out_valid <= 1'b1;
        out_data <= '{result_kind: 1'b0, tx_byte: fbyte, tx_last: (bcnt == 3'd7),
                      pump_fail: 1'b0, motor_onoff: onoff_map, frame_accepted: 1'b0};
        bcnt <= bcnt + 3'd1;
      end

      // Walk one slave entry per cycle; the last entry is held while the output is not free
      if (cmd.scan_step && item.link_enabled) begin
        if (s_active) begin
          if (s_cur[9:8] != 2'd0 || s_cur[7:0] >= miss_limit) fail <= 1'b1;
        end else begin
          slave_status[scan_idx] <= {s_cur[13:10], 10'd0};
        end
      end
      if (cmd.scan_step && !sts.last_scan) scan_idx <= scan_idx + IW'(1);

      // Present the status beat and, when the link is enabled, drop the receive buffer
      if (cmd.emit_stat) begin
        out_valid <= 1'b1;
        out_data <= '{result_kind: 1'b1, tx_byte: 8'd0, tx_last: 1'b0,
                      pump_fail: item.link_enabled &&
                        (fail || (s_active && (s_cur[9:8] != 2'd0 || s_cur[7:0] >= miss_limit))),
                      motor_onoff: onoff_map, frame_accepted: accepted};
        if (item.link_enabled) begin
          rx_length <= 4'd0;
          rx_crc <= CRC_INIT;
          rx_addr <= 8'd0;
          rx_reg <= 8'd0;
        end
      end
    end
  end
endmodule

@@ rtl/modbus_motor_poll_monitor_unit.sv @@
// Top level: Modbus motor poll monitor
// One item is accepted when the block is idle. A received byte, an ignored item or a poll
// that sends no frame passes through load and decode only; a poll with a frame runs the CRC
// (six byte steps and one settle), then 8 output beats, set by the byte-serial frame builder;
// a completion runs the health scan (one slave entry per cycle). Output stalls hold both the
// beats and the last scan entry. Output beats stand in a register.
module modbus_motor_poll_monitor_unit #(
  parameter int unsigned MAX_SLAVES = mbmon_pkg::MAX_SLAVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mbmon_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mbmon_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import mbmon_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_free;

  assign cfg_ready = 1'b1;

  mbmon_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_free(out_free), .sts(sts), .cmd(cmd)
  );

  mbmon_dp #(.MAX_SLAVES(MAX_SLAVES)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index[0]), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .out_free(out_free), .out_stall(out_stall),
    .out_valid(out_valid), .out_data(out_data)
  );
endmodule

@@ rtl/mbmon_checker.sv @@
// Checker: port-level properties of the motor poll monitor
`include "assert_macros.svh"
module mbmon_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mbmon_pkg::out_item_t out_data
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled beat changed")
  `CHK_IMPLY(a_tx_clean, clk, rst, out_valid && !out_data.result_kind, !out_data.pump_fail && !out_data.frame_accepted, "frame beat carries status")
  `CHK_IMPLY(a_stat_clean, clk, rst, out_valid && out_data.result_kind, out_data.tx_byte == 8'd0 && !out_data.tx_last, "status beat carries frame bits")
  `CHK_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "accepted item not held")
endmodule

bind modbus_motor_poll_monitor_unit mbmon_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ tb/testbench.sv @@
// Testbench for the Modbus motor poll monitor: predicts frame and status beats and checks them
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbmon_pkg::*;

  // Predictor of the poll monitor; holds slave health and receive state
  class poll_scoreboard;
    logic [3:0]  motor_count;
    logic [7:0]  miss_limit;
    logic [13:0] slave_status [0:8];
    logic [3:0]  poll_ptr;
    logic [3:0]  reply_ptr;
    logic [3:0]  rx_len;
    logic [15:0] rx_crc;
    logic [7:0]  rx_addr;
    logic [7:0]  rx_reg;
    logic [7:0]  onoff_map;
    out_item_t   pending [$];
    int          errors;

    function void reset_state();
      motor_count = 4'd1;
      miss_limit = 8'd3;
      for (int i = 0; i <= 8; i++) slave_status[i] = '0;
      poll_ptr = 4'd1;
      reply_ptr = 4'd1;
      onoff_map = '0;
      errors = 0;
      clear_rx();
    endfunction

    function void clear_rx();
      rx_len = '0;
      rx_crc = 16'hFFFF;
      rx_addr = '0;
      rx_reg = '0;
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
    endfunction

    function logic [7:0] tank_map(int n, logic [3:0] t);
      logic [7:0] m;
      logic [1:0] p0, p1, p2, p3;
      p0 = {2{t[0]}};
      p1 = {2{t[1]}};
      p2 = {2{t[2]}};
      p3 = {2{t[3]}};
      case (n)
        1: m = {7'd0, |t};
        2: m = {6'd0, t[2] | t[3], t[0] | t[1]};
        3: m = {5'd0, t[2] | t[3], t[1], t[0]};
        4: m = {4'd0, t};
        5: m = {3'd0, t[3], t[2], t[1], p0};
        6: m = {2'd0, t[3], t[2], p1, p0};
        7: m = {1'b0, t[3], p2, p1, p0};
        8: m = {p3, p2, p1, p0};
        default: m = 8'd0;
      endcase
      return m;
    endfunction

    function void clear_health();
      for (int i = 1; i <= 8; i++) slave_status[i] &= 14'h3C00;
    endfunction

    // Note one accepted input beat and queue the beats it causes
    function void note_input(in_item_t it);
      int n, ptr;
      logic [7:0] f [8];
      logic [15:0] c;
      logic [7:0] miss;
      logic fail, ok;
      out_item_t o;
      n = (motor_count > 8) ? 8 : motor_count;
      case (op_t'(it.operation))
        OP_RX_BYTE: begin
          rx_crc = crc_byte(rx_crc, it.rx_byte);
          if (rx_len == 0) rx_addr = it.rx_byte;
          else if (rx_len == 5) rx_reg = it.rx_byte;
          if (rx_len < 15) rx_len++;
        end
        OP_POLL: begin
          ptr = (poll_ptr >= 1 && poll_ptr <= 8) ? poll_ptr : 1;
          if (it.machine_mode == MODE_MANUAL) onoff_map = 8'hFF;
          else if (it.machine_mode == MODE_OFF) onoff_map = 8'h00;
          else onoff_map = tank_map(n, it.tank_states);
          if (n > 0) begin
            if (it.link_enabled) begin
              f[0] = 8'(ptr); f[1] = FUNC_WRITE_REG; f[2] = 8'd0; f[3] = 8'd0; f[4] = 8'd0;
              f[5] = {7'd0, onoff_map[ptr-1]};
              c = 16'hFFFF;
              for (int i = 0; i < 6; i++) c = crc_byte(c, f[i]);
              f[6] = c[7:0];
              f[7] = c[15:8];
              for (int i = 0; i < 8; i++) begin
                o = '0;
                o.tx_byte = f[i];
                o.tx_last = (i == 7);
                o.motor_onoff = onoff_map;
                pending.push_back(o);
              end
              clear_rx();
            end
          end else clear_health();
          reply_ptr = 4'(ptr);
          poll_ptr = (n > 0 && ptr < n) ? 4'(ptr + 1) : 4'd1;
        end
        OP_COMPLETE: begin
          ok = 0;
          fail = 0;
          if (it.link_enabled) begin
            ok = (rx_len == 8 && rx_crc == 0);
            if (ok) begin
              if (rx_addr <= 8)
                slave_status[4'(rx_addr)] = {rx_reg[5:4], rx_reg[3:2], rx_reg[1], rx_reg[0],
                                             8'd0};
            end else if (reply_ptr <= 8) begin
              miss = slave_status[reply_ptr][7:0];
              miss = (miss < miss_limit) ? miss + 8'd1 : miss_limit;
              slave_status[reply_ptr] = {slave_status[reply_ptr][13:8], miss};
            end
            for (int i = 1; i <= 8; i++) begin
              if (i <= n && it.power_on) begin
                if (slave_status[i][9:8] != 0 || slave_status[i][7:0] >= miss_limit) fail = 1;
              end else slave_status[i] &= 14'h3C00;
            end
            clear_rx();
          end else clear_health();
          o = '0;
          o.result_kind = 1'b1;
          o.pump_fail = fail;
          o.motor_onoff = onoff_map;
          o.frame_accepted = ok;
          pending.push_back(o);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted output beat with the oldest expectation
    function void check_output(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.result_kind !== e.result_kind) begin
        $error("result_kind exp %0d got %0d", e.result_kind, got.result_kind); errors++;
      end
      if (got.tx_byte !== e.tx_byte) begin
        $error("tx_byte exp %h got %h", e.tx_byte, got.tx_byte); errors++;
      end
      if (got.tx_last !== e.tx_last) begin
        $error("tx_last exp %0d got %0d", e.tx_last, got.tx_last); errors++;
      end
      if (got.pump_fail !== e.pump_fail) begin
        $error("pump_fail exp %0d got %0d", e.pump_fail, got.pump_fail); errors++;
      end
      if (got.motor_onoff !== e.motor_onoff) begin
        $error("motor_onoff exp %h got %h", e.motor_onoff, got.motor_onoff); errors++;
      end
      if (got.frame_accepted !== e.frame_accepted) begin
        $error("frame_accepted exp %0d got %0d", e.frame_accepted, got.frame_accepted);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;
  poll_scoreboard sb;
  int cycles;
  bit calm;
  bit long_hold;

  modbus_motor_poll_monitor_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sample accepted beats on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(in_data);
    if (!rst && out_valid && !out_stall) sb.check_output(out_data);
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_stall = 0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_stall = 1;
        repeat (300) @(negedge clk);
        long_hold = 0;
        out_stall = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall = 1;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk);
        out_stall = 0;
      end
      @(negedge clk);
    end
  end

  task automatic send_item(in_item_t it);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 15);
      repeat (n) @(negedge clk);
    end
    in_valid = 1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MOTOR_COUNT) sb.motor_count = val[3:0];
    else sb.miss_limit = val;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Let the block drain before a register write
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [7:0] b, logic link);
    in_item_t it;
    it.operation = op;
    it.rx_byte = b;
    it.link_enabled = link;
    it.machine_mode = 2'($urandom_range(0, 3));
    it.tank_states = 4'($urandom_range(0, 15));
    it.power_on = ($urandom_range(0, 5) != 0);
    return it;
  endfunction

  // Send a well-formed or damaged reply for a slave, then complete it
  task automatic send_reply(logic [7:0] addr, logic [7:0] status, int damage);
    logic [7:0] f [8];
    logic [15:0] c;
    int len;
    f[0] = addr; f[1] = FUNC_WRITE_REG; f[2] = 8'd0; f[3] = 8'd0; f[4] = 8'd0; f[5] = status;
    c = 16'hFFFF;
    for (int i = 0; i < 6; i++) c = sb.crc_byte(c, f[i]);
    f[6] = c[7:0];
    f[7] = c[15:8];
    if (damage == 1) f[6] ^= 8'h01;
    len = (damage == 2) ? $urandom_range(0, 7) : 8;
    for (int i = 0; i < len; i++)
      send_item(make_item(OP_RX_BYTE, f[i], 1'($urandom_range(0, 1))));
    if (damage == 3)
      repeat ($urandom_range(1, 10))
        send_item(make_item(OP_RX_BYTE, 8'($urandom), 1'b1));
    send_item(make_item(OP_COMPLETE, 8'd0, $urandom_range(0, 9) != 0));
  endtask

  task automatic poll_round(int items);
    in_item_t it;
    int k;
    for (int j = 0; j < items; j++) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        it = make_item(OP_POLL, 8'($urandom), $urandom_range(0, 7) != 0);
        send_item(it);
      end else if (k < 8)
        send_reply(8'($urandom_range(0, 8)), 8'($urandom), (k == 7) ? $urandom_range(1, 3) : 0);
      else if (k == 8) send_reply(8'($urandom_range(9, 255)), 8'($urandom), 0);
      else send_item(make_item(2'($urandom_range(0, 3)), 8'($urandom),
                               1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    in_item_t it;
    sb = new();
    sb.reset_state();
    cycles = 0;
    calm = 0;
    long_hold = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // Directed: every mode, every op, extremes, empty and ignored items
    for (int m = 0; m < 4; m++) begin
      it = make_item(OP_POLL, 8'hFF, 1'b1);
      it.machine_mode = 2'(m);
      it.tank_states = 4'hF;
      send_item(it);
    end
    send_reply(8'd1, 8'h3F, 0);
    send_reply(8'd1, 8'h00, 0);
    send_reply(8'd0, 8'hFF, 0);
    send_reply(8'd200, 8'h01, 0);
    send_reply(8'd1, 8'h00, 3);
    send_reply(8'd1, 8'h00, 1);
    send_item(make_item(OP_NONE, 8'h00, 1'b1));
    send_item(make_item(OP_POLL, 8'h00, 1'b0));
    send_item(make_item(OP_COMPLETE, 8'h00, 1'b0));

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(CFG_MOTOR_COUNT, (ph == 0) ? 8'd8 : (ph == 1) ? 8'd0 :
                (ph == 2) ? 8'd15 : 8'($urandom_range(1, 8)));
      write_reg(CFG_MISS_LIMIT, (ph == 3) ? 8'd255 : (ph == 4) ? 8'd1 :
                (ph == 5) ? 8'd0 : 8'($urandom_range(1, 6)));
      if (ph == 2) long_hold = 1;
      if (ph == 7) calm = 1;
      poll_round(8);
      if (ph == 4) while (sb.pending.size() != 0) @(negedge clk);
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
